// ===== hw/rtl/mmt_pkg.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// mmt_pkg
// shared types and constants of the multiscale morphological transform
// ----------------------------------------------------------------------------
package mmt_pkg;

    localparam int HALF_WINDOW_DEF = 24;
    localparam int SAMPLE_W        = 16;
    localparam int OUT_W           = 17;
    localparam int NUM_W           = 18;
    localparam int MAG_W           = 17;

    localparam logic [OUT_W-1:0]    OUT_MAX       = 17'd65535;
    localparam logic [SAMPLE_W-1:0] INVALID_RESET = 16'h8000;

    typedef enum logic [2:0] {
        ST_IDLE,
        ST_SCAN,
        ST_PREP,
        ST_DIV,
        ST_OUT
    } state_t;

endpackage

// ===== hw/rtl/multiscale_morphological_transform.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// multiscale_morphological_transform
// window max + min - 2 * centre over 2*HALF_WINDOW+1 samples, divided by HALF_WINDOW
// no input beat is taken while a result is being computed: in_stall stays high from
//   the beat that fills the window until its result is loaded into the output register
// the result comes from a one-entry-per-cycle scan of the window memory and a
//   reciprocal multiply
// while the window fills, an input beat is stored and gives no result
// reset: fill count and control cleared, invalid code -32768, window memory not cleared
// ----------------------------------------------------------------------------
module multiscale_morphological_transform #(
    parameter int HALF_WINDOW = mmt_pkg::HALF_WINDOW_DEF
) (
    input  logic                                clk,
    input  logic                                rst_n,
    input  logic                                cfg_wr_en,
    input  logic signed [mmt_pkg::SAMPLE_W-1:0] cfg_wr_data,
    input  logic                                in_valid,
    output logic                                in_stall,
    input  logic signed [mmt_pkg::SAMPLE_W-1:0] sample,
    output logic                                out_valid,
    input  logic                                out_stall,
    output logic signed [mmt_pkg::OUT_W-1:0]    transform_value,
    output logic                                no_valid_sample
);

    localparam int WIN_LEN = 2 * HALF_WINDOW + 1;
    localparam int AW      = $clog2(WIN_LEN);
    localparam int CW      = $clog2(WIN_LEN + 1);

    localparam int SW = mmt_pkg::SAMPLE_W;
    localparam int NW = mmt_pkg::NUM_W;
    localparam int MW = mmt_pkg::MAG_W;
    localparam int OW = mmt_pkg::OUT_W;

    // reciprocal of HALF_WINDOW, exact floor quotient for any MW-bit magnitude
    localparam int RL    = $clog2(HALF_WINDOW);
    localparam int RS    = MW + RL;
    localparam int RW    = MW + 2;
    localparam int PW    = MW + RS;
    localparam int RECIP = ((1 << RS) + HALF_WINDOW - 1) / HALF_WINDOW;

    localparam logic [RW-1:0] RECIP_M = RW'(RECIP);

    mmt_pkg::state_t state_reg, state_next;

    logic signed [SW-1:0] mem [WIN_LEN];

    logic [CW-1:0]        fill_reg;
    logic [AW-1:0]        wr_ptr_reg;
    logic [AW-1:0]        centre_addr_reg;
    logic [CW-1:0]        rd_cnt_reg;
    logic                 rd_vld_reg;
    logic                 rd_last_reg;
    logic                 rd_centre_reg;
    logic signed [SW-1:0] rd_data_reg;
    logic signed [SW-1:0] mx_reg;
    logic signed [SW-1:0] mn_reg;
    logic signed [SW-1:0] centre_reg;
    logic                 any_reg;
    logic                 neg_reg;
    logic [MW-1:0]        mag_reg;
    logic signed [SW-1:0] invalid_code_reg;
    logic                 out_valid_reg;
    logic signed [OW-1:0] out_value_reg;
    logic                 out_flag_reg;

    logic                 in_accept;
    logic                 scan_start;
    logic                 rd_issue;
    logic                 scan_done;
    logic                 div_done;
    logic                 out_load;

    logic [NW-1:0]        num;
    logic [NW-1:0]        num_abs;
    logic [PW-1:0]        prod;
    logic [OW-1:0]        sat_mag;
    logic [AW-1:0]        centre_addr;
    logic                 sample_ok;

    // next state
    always_comb
    begin
        state_next = state_reg;
        case (state_reg)
            mmt_pkg::ST_IDLE:
            begin
                if (scan_start)
                    state_next = mmt_pkg::ST_SCAN;
            end
            mmt_pkg::ST_SCAN:
            begin
                if (scan_done)
                    state_next = mmt_pkg::ST_PREP;
            end
            mmt_pkg::ST_PREP:
            begin
                state_next = any_reg ? mmt_pkg::ST_DIV : mmt_pkg::ST_OUT;
            end
            mmt_pkg::ST_DIV:
            begin
                if (div_done)
                    state_next = mmt_pkg::ST_OUT;
            end
            mmt_pkg::ST_OUT:
            begin
                if (out_load)
                    state_next = mmt_pkg::ST_IDLE;
            end
            default:
            begin
                state_next = mmt_pkg::ST_IDLE;
            end
        endcase
    end

    // control strobes
    always_comb
    begin
        in_stall   = 1'b1;
        in_accept  = 1'b0;
        scan_start = 1'b0;
        rd_issue   = 1'b0;
        div_done   = 1'b0;
        out_load   = 1'b0;
        case (state_reg)
            mmt_pkg::ST_IDLE:
            begin
                in_stall   = 1'b0;
                in_accept  = in_valid;
                scan_start = in_valid && (fill_reg >= CW'(WIN_LEN - 1));
            end
            mmt_pkg::ST_SCAN:
            begin
                rd_issue = (rd_cnt_reg < CW'(WIN_LEN));
            end
            mmt_pkg::ST_DIV:
            begin
                div_done = 1'b1;
            end
            mmt_pkg::ST_OUT:
            begin
                out_load = !out_valid_reg || !out_stall;
            end
            default:
            begin
                in_stall = 1'b1;
            end
        endcase
    end

    assign scan_done = rd_vld_reg && rd_last_reg;

    assign centre_addr = (wr_ptr_reg >= AW'(HALF_WINDOW))
                       ? wr_ptr_reg - AW'(HALF_WINDOW)
                       : wr_ptr_reg + AW'(WIN_LEN - HALF_WINDOW);

    assign sample_ok = (rd_data_reg != invalid_code_reg);

    assign num = {{2{mx_reg[SW-1]}}, mx_reg} + {{2{mn_reg[SW-1]}}, mn_reg}
               - {centre_reg[SW-1], centre_reg, 1'b0};
    assign num_abs = num[NW-1] ? (~num + NW'(1)) : num;

    assign prod = {{(PW - MW){1'b0}}, mag_reg} * {{(PW - RW){1'b0}}, RECIP_M};

    assign sat_mag = (mag_reg > mmt_pkg::OUT_MAX) ? mmt_pkg::OUT_MAX : mag_reg;

    // window memory
    always_ff @(posedge clk)
    begin
        if (in_accept)
            mem[wr_ptr_reg] <= sample;
        rd_data_reg <= mem[rd_cnt_reg[AW-1:0]];
    end

    // control registers
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg        <= mmt_pkg::ST_IDLE;
            fill_reg         <= '0;
            wr_ptr_reg       <= '0;
            rd_cnt_reg       <= '0;
            rd_vld_reg       <= 1'b0;
            rd_last_reg      <= 1'b0;
            invalid_code_reg <= mmt_pkg::INVALID_RESET;
            out_valid_reg    <= 1'b0;
        end
        else
        begin
            state_reg <= state_next;

            if (cfg_wr_en)
                invalid_code_reg <= cfg_wr_data;

            if (in_accept)
            begin
                if (fill_reg < CW'(WIN_LEN))
                    fill_reg <= fill_reg + CW'(1);
                wr_ptr_reg <= (wr_ptr_reg == AW'(WIN_LEN - 1)) ? '0 : wr_ptr_reg + AW'(1);
            end

            if (scan_start)
                rd_cnt_reg <= '0;
            else if (rd_issue)
                rd_cnt_reg <= rd_cnt_reg + CW'(1);

            rd_vld_reg  <= rd_issue;
            rd_last_reg <= rd_issue && (rd_cnt_reg == CW'(WIN_LEN - 1));

            if (out_load)
                out_valid_reg <= 1'b1;
            else if (!out_stall)
                out_valid_reg <= 1'b0;
        end
    end

    // datapath
    always_ff @(posedge clk)
    begin
        if (scan_start)
        begin
            centre_addr_reg <= centre_addr;
            any_reg         <= 1'b0;
        end

        rd_centre_reg <= (rd_cnt_reg[AW-1:0] == centre_addr_reg);

        if (rd_vld_reg)
        begin
            if (rd_centre_reg)
                centre_reg <= rd_data_reg;
            if (sample_ok)
            begin
                any_reg <= 1'b1;
                if (!any_reg || (rd_data_reg > mx_reg))
                    mx_reg <= rd_data_reg;
                if (!any_reg || (rd_data_reg < mn_reg))
                    mn_reg <= rd_data_reg;
            end
        end

        if (state_reg == mmt_pkg::ST_PREP)
        begin
            if (any_reg)
            begin
                neg_reg <= num[NW-1];
                mag_reg <= num_abs[MW-1:0];
            end
            else
            begin
                neg_reg <= 1'b0;
                mag_reg <= '0;
            end
        end
        else if (state_reg == mmt_pkg::ST_DIV)
        begin
            mag_reg <= prod[RS +: MW];
        end

        if (out_load)
        begin
            out_value_reg <= neg_reg ? $signed(~sat_mag + OW'(1)) : $signed(sat_mag);
            out_flag_reg  <= !any_reg;
        end
    end

    assign out_valid       = out_valid_reg;
    assign transform_value = out_value_reg;
    assign no_valid_sample = out_flag_reg;

endmodule

// ===== hw/rtl/mmt_checker.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// mmt_checker
// port-level checks of the multiscale morphological transform
// ----------------------------------------------------------------------------
module mmt_checker (
    input logic                                clk,
    input logic                                rst_n,
    input logic                                in_valid,
    input logic                                in_stall,
    input logic                                out_valid,
    input logic                                out_stall,
    input logic signed [mmt_pkg::OUT_W-1:0]    transform_value,
    input logic                                no_valid_sample
);

    // a stalled result beat holds
    a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && out_stall |=> out_valid && $stable(transform_value)
                                  && $stable(no_valid_sample))
        else $error("stalled result beat changed");

    // an input beat never yields a result in the next cycle
    a_in_to_out: assert property (@(posedge clk) disable iff (!rst_n)
        in_valid && !in_stall |=> !$rose(out_valid))
        else $error("result too soon after input beat");

    // a window with no valid sample gives a zero value
    a_empty_zero: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && no_valid_sample |-> transform_value == '0)
        else $error("nonzero value with no valid sample");

    // value stays within the saturation range
    a_range: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid |-> transform_value != 17'h10000)
        else $error("value outside saturation range");

endmodule

bind multiscale_morphological_transform mmt_checker u_mmt_checker (
    .clk             (clk),
    .rst_n           (rst_n),
    .in_valid        (in_valid),
    .in_stall        (in_stall),
    .out_valid       (out_valid),
    .out_stall       (out_stall),
    .transform_value (transform_value),
    .no_valid_sample (no_valid_sample)
);
